@@ hw/rtl/lvr_pkg.sv @@
// ----------------------------------------------------------------------------
// Look-at view rotation package
// Shared widths, the Q1.30 result type and the sign and saturation helper.
// ----------------------------------------------------------------------------
package lvr_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int OUT_W   = 32;
    localparam int PROD_W  = 64;
    localparam int MAG_W   = 33;

    localparam logic [MAG_W-1:0] ONE_Q30 = MAG_W'(64'h4000_0000);

    typedef logic signed [OUT_W-1:0] q30_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    function automatic q30_t sign_sat(input logic [MAG_W-1:0] mag, input logic neg);
        logic [MAG_W-1:0] lim;
        lim = (mag > ONE_Q30) ? ONE_Q30 : mag;
        return neg ? -q30_t'(lim[OUT_W-1:0]) : q30_t'(lim[OUT_W-1:0]);
    endfunction

endpackage

@@ hw/rtl/lvr_norm.sv @@
// ----------------------------------------------------------------------------
// Vector normaliser
// Scales a signed 3-vector to Q1.30 unit length: block scaling, squares,
// a bit-per-stage square root and three bit-per-stage dividers.
// ----------------------------------------------------------------------------
module lvr_norm #(
    parameter int W  = 33,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic signed [W-1:0] vec [3],
    input  logic [SW-1:0]       side_in,
    output logic                out_valid,
    output logic                out_zero,
    output lvr_pkg::q30_t       nrm [3],
    output logic [SW-1:0]       side_out
);
    import lvr_pkg::*;

    localparam int NG   = (W + 7) / 8;
    localparam int PW   = $clog2(NG * 8);
    localparam int CW   = SW + 4;
    localparam int NSQ  = 31;
    localparam int NDV  = 31;
    localparam int ST_P = 2;
    localparam int L    = 6 + NSQ + 1 + NDV + 1;

    function automatic logic [2:0] lzc8(input logic [7:0] b);
        logic [2:0] c;
        logic       f;
        c = '0;
        f = 1'b0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!f)
            begin
                if (b[k])
                    f = 1'b1;
                else
                    c = c + 3'd1;
            end
        end
        return c;
    endfunction

    logic          vld_reg [L];
    logic [CW-1:0] car_reg [L];
    logic [CW-1:0] car0_next;

    logic [W-1:0]  mag0_reg [3];
    logic [W-1:0]  mag0_next [3];
    logic [W-1:0]  or0_reg;
    logic [W-1:0]  or0_next;
    logic [W-1:0]  mag1_reg [3];
    logic [NG-1:0] nz1_reg;
    logic [NG-1:0] nz1_next;
    logic [2:0]    lz1_reg [NG];
    logic [2:0]    lz1_next [NG];
    logic [W-1:0]  mag2_reg [3];
    logic [PW-1:0] p2_reg;
    logic [PW-1:0] p2_next;
    logic          zero2;
    logic [29:0]   sm3_reg [3];
    logic [29:0]   sm3_next [3];
    logic [29:0]   sm4_reg [3];
    logic [59:0]   sq4_reg [3];
    logic [59:0]   sq4_next [3];
    logic [29:0]   sm5_reg [3];
    logic [61:0]   sum5_reg;
    logic [61:0]   sum5_next;

    logic [32:0]   sq_rem_reg [NSQ];
    logic [32:0]   sq_rem_next [NSQ];
    logic [30:0]   sq_root_reg [NSQ];
    logic [30:0]   sq_root_next [NSQ];
    logic [61:0]   sq_x_reg [NSQ];
    logic [61:0]   sq_x_next [NSQ];
    logic [29:0]   sq_sm_reg [NSQ][3];
    logic [29:0]   sq_sm_next [NSQ][3];

    logic [30:0]   pr_r_reg [3];
    logic [30:0]   pr_r_next [3];
    logic [30:0]   pr_nlo_reg [3];
    logic [30:0]   pr_nlo_next [3];
    logic [30:0]   pr_m_reg;

    logic [30:0]   dv_r_reg [NDV][3];
    logic [30:0]   dv_r_next [NDV][3];
    logic [30:0]   dv_nlo_reg [NDV][3];
    logic [30:0]   dv_nlo_next [NDV][3];
    logic [30:0]   dv_q_reg [NDV][3];
    logic [30:0]   dv_q_next [NDV][3];
    logic [30:0]   dv_m_reg [NDV];
    logic [30:0]   dv_m_next [NDV];

    q30_t          nrm_reg [3];
    q30_t          nrm_next [3];

    always_comb
    begin
        car0_next = {1'b0, vec[2][W-1], vec[1][W-1], vec[0][W-1], side_in};
        or0_next  = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag0_next[i] = vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
            or0_next     = or0_next | mag0_next[i];
        end
    end

    always_comb
    begin
        logic [NG*8-1:0] padded;
        padded = (NG * 8)'(or0_reg);
        for (int g = 0; g < NG; g++)
        begin
            nz1_next[g] = |padded[8*g +: 8];
            lz1_next[g] = lzc8(padded[8*g +: 8]);
        end
    end

    always_comb
    begin
        p2_next = '0;
        zero2   = ~(|nz1_reg);
        for (int g = 0; g < NG; g++)
        begin
            if (nz1_reg[g])
                p2_next = PW'(g * 8 + 7) - PW'(lz1_reg[g]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (p2_reg >= PW'(29))
                sm3_next[i] = 30'(mag2_reg[i] >> (p2_reg - PW'(29)));
            else
                sm3_next[i] = mag2_reg[i][29:0] << (PW'(29) - p2_reg);
            sq4_next[i] = 60'(sm3_reg[i]) * 60'(sm3_reg[i]);
        end
        sum5_next = 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
    end

    always_comb
    begin
        logic [32:0] rp;
        logic [32:0] rs;
        logic [32:0] tr;
        logic [30:0] op;
        logic [61:0] xp;
        for (int t = 0; t < NSQ; t++)
        begin
            if (t == 0)
            begin
                rp = '0;
                op = '0;
                xp = sum5_reg;
                sq_sm_next[t] = sm5_reg;
            end
            else
            begin
                rp = sq_rem_reg[t-1];
                op = sq_root_reg[t-1];
                xp = sq_x_reg[t-1];
                sq_sm_next[t] = sq_sm_reg[t-1];
            end
            rs = {rp[30:0], xp[2*(NSQ-1-t) +: 2]};
            tr = {op, 2'b01};
            if (rs >= tr)
            begin
                sq_rem_next[t]  = rs - tr;
                sq_root_next[t] = {op[29:0], 1'b1};
            end
            else
            begin
                sq_rem_next[t]  = rs;
                sq_root_next[t] = {op[29:0], 1'b0};
            end
            sq_x_next[t] = xp;
        end
    end

    always_comb
    begin
        logic [60:0] n61;
        for (int i = 0; i < 3; i++)
        begin
            n61 = 61'({sq_sm_reg[NSQ-1][i], 30'b0}) + 61'(sq_root_reg[NSQ-1][30:1]);
            pr_r_next[i]   = 31'(n61[60:31]);
            pr_nlo_next[i] = n61[30:0];
        end
    end

    always_comb
    begin
        logic [31:0] trial;
        logic [30:0] rp;
        logic [30:0] nl;
        logic [30:0] qp;
        logic [30:0] mp;
        for (int t = 0; t < NDV; t++)
        begin
            mp = (t == 0) ? pr_m_reg : dv_m_reg[t-1];
            dv_m_next[t] = mp;
            for (int i = 0; i < 3; i++)
            begin
                if (t == 0)
                begin
                    rp = pr_r_reg[i];
                    nl = pr_nlo_reg[i];
                    qp = '0;
                end
                else
                begin
                    rp = dv_r_reg[t-1][i];
                    nl = dv_nlo_reg[t-1][i];
                    qp = dv_q_reg[t-1][i];
                end
                trial = {rp, nl[NDV-1-t]};
                if (trial >= {1'b0, mp})
                begin
                    dv_r_next[t][i] = 31'(trial - {1'b0, mp});
                    qp[NDV-1-t]     = 1'b1;
                end
                else
                begin
                    dv_r_next[t][i] = trial[30:0];
                end
                dv_q_next[t][i]   = qp;
                dv_nlo_next[t][i] = nl;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            nrm_next[i] = sign_sat(MAG_W'(dv_q_reg[NDV-1][i]), car_reg[L-2][SW+i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < L; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            car_reg[0] <= car0_next;
            for (int i = 1; i < L; i++)
                car_reg[i] <= (i == ST_P) ? {zero2, car_reg[i-1][CW-2:0]} : car_reg[i-1];
            mag0_reg <= mag0_next;
            or0_reg  <= or0_next;
            mag1_reg <= mag0_reg;
            nz1_reg  <= nz1_next;
            lz1_reg  <= lz1_next;
            mag2_reg <= mag1_reg;
            p2_reg   <= p2_next;
            sm3_reg  <= sm3_next;
            sm4_reg  <= sm3_reg;
            sq4_reg  <= sq4_next;
            sm5_reg  <= sm4_reg;
            sum5_reg <= sum5_next;
            sq_rem_reg  <= sq_rem_next;
            sq_root_reg <= sq_root_next;
            sq_x_reg    <= sq_x_next;
            sq_sm_reg   <= sq_sm_next;
            pr_r_reg    <= pr_r_next;
            pr_nlo_reg  <= pr_nlo_next;
            pr_m_reg    <= sq_root_reg[NSQ-1];
            dv_r_reg    <= dv_r_next;
            dv_nlo_reg  <= dv_nlo_next;
            dv_q_reg    <= dv_q_next;
            dv_m_reg    <= dv_m_next;
            nrm_reg     <= nrm_next;
        end
    end

    assign out_valid = vld_reg[L-1];
    assign out_zero  = car_reg[L-1][CW-1];
    assign side_out  = car_reg[L-1][SW-1:0];
    assign nrm       = nrm_reg;

endmodule

@@ hw/rtl/lookat_view_rotation.sv @@
// ----------------------------------------------------------------------------
// Look-at view rotation
// Builds the 3x3 view rotation (side, recomputed up, negated forward) from
// an eye point, a target point and an up vector.
// ----------------------------------------------------------------------------
// Each item on the source channel (src_valid, src_stall) carries the eye,
// target and up coordinates in signed Q16.16. Each item on the result
// channel (res_valid, res_stall) carries the nine Q1.30 entries and the
// degenerate flag, which is set, with all entries zero, when the forward
// or the side vector has zero length.
// Exactly one result leaves for every item taken. One item can be taken in
// every cycle while no waiting result is stalled. The depth comes from two
// normalisers, each with a 31-stage square root and 31-stage dividers,
// working one result bit per stage.
// The whole pipeline advances as one; while the receiver stalls a waiting
// result, every stage holds and src_stall is raised, so nothing is lost or
// repeated. Reset empties the pipeline; no state survives between items.
// ----------------------------------------------------------------------------
module lookat_view_rotation (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  lvr_pkg::coord_t eye_x,
    input  lvr_pkg::coord_t eye_y,
    input  lvr_pkg::coord_t eye_z,
    input  lvr_pkg::coord_t target_x,
    input  lvr_pkg::coord_t target_y,
    input  lvr_pkg::coord_t target_z,
    input  lvr_pkg::coord_t upin_x,
    input  lvr_pkg::coord_t upin_y,
    input  lvr_pkg::coord_t upin_z,
    output logic           res_valid,
    input  logic           res_stall,
    output lvr_pkg::q30_t  row0_x,
    output lvr_pkg::q30_t  row0_y,
    output lvr_pkg::q30_t  row0_z,
    output lvr_pkg::q30_t  row1_x,
    output lvr_pkg::q30_t  row1_y,
    output lvr_pkg::q30_t  row1_z,
    output lvr_pkg::q30_t  row2_x,
    output lvr_pkg::q30_t  row2_y,
    output lvr_pkg::q30_t  row2_z,
    output logic           degenerate
);
    import lvr_pkg::*;

    localparam int UP_W = 3 * COORD_W;
    localparam int F_W  = 3 * OUT_W;

    logic adv;

    logic                    t0_valid_reg;
    logic signed [DIFF_W-1:0] fwd_reg [3];
    coord_t                  up0_reg [3];

    logic            n1_valid;
    logic            n1_zero;
    q30_t            f1 [3];
    logic [UP_W-1:0] n1_side;

    logic  t1_valid_reg;
    prod_t pr1_reg [6];
    q30_t  f_t1_reg [3];
    logic  zf_t1_reg;

    logic  t2_valid_reg;
    prod_t side_reg [3];
    q30_t  f_t2_reg [3];
    logic  zf_t2_reg;

    logic             n2_valid;
    logic             n2_zero;
    q30_t             s2 [3];
    logic [F_W:0]     n2_side;
    q30_t             f_n2 [3];

    logic  t3_valid_reg;
    prod_t pr3_reg [6];
    q30_t  s_t3_reg [3];
    q30_t  f_t3_reg [3];
    logic  dg_t3_reg;

    logic  t4_valid_reg;
    prod_t u_reg [3];
    q30_t  s_t4_reg [3];
    q30_t  f_t4_reg [3];
    logic  dg_t4_reg;

    logic  res_valid_reg;
    q30_t  row_reg [9];
    q30_t  row_next [9];
    logic  dg_reg;

    coord_t up_n1 [3];

    assign adv       = ~res_valid_reg | ~res_stall;
    assign src_stall = ~adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg  <= 1'b0;
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            t4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_valid_reg  <= src_valid;
            t1_valid_reg  <= n1_valid;
            t2_valid_reg  <= t1_valid_reg;
            t3_valid_reg  <= n2_valid;
            t4_valid_reg  <= t3_valid_reg;
            res_valid_reg <= t4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_reg[0] <= DIFF_W'(target_x) - DIFF_W'(eye_x);
            fwd_reg[1] <= DIFF_W'(target_y) - DIFF_W'(eye_y);
            fwd_reg[2] <= DIFF_W'(target_z) - DIFF_W'(eye_z);
            up0_reg[0] <= upin_x;
            up0_reg[1] <= upin_y;
            up0_reg[2] <= upin_z;
        end
    end

    lvr_norm #(
        .W  (DIFF_W),
        .SW (UP_W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t0_valid_reg),
        .vec       (fwd_reg),
        .side_in   ({up0_reg[2], up0_reg[1], up0_reg[0]}),
        .out_valid (n1_valid),
        .out_zero  (n1_zero),
        .nrm       (f1),
        .side_out  (n1_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up_n1[i] = coord_t'(n1_side[COORD_W*i +: COORD_W]);
            f_n2[i]  = q30_t'(n2_side[OUT_W*i +: OUT_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr1_reg[0] <= PROD_W'(up_n1[1]) * PROD_W'(f1[2]);
            pr1_reg[1] <= PROD_W'(up_n1[2]) * PROD_W'(f1[1]);
            pr1_reg[2] <= PROD_W'(up_n1[2]) * PROD_W'(f1[0]);
            pr1_reg[3] <= PROD_W'(up_n1[0]) * PROD_W'(f1[2]);
            pr1_reg[4] <= PROD_W'(up_n1[0]) * PROD_W'(f1[1]);
            pr1_reg[5] <= PROD_W'(up_n1[1]) * PROD_W'(f1[0]);
            f_t1_reg   <= f1;
            zf_t1_reg  <= n1_zero;
            for (int i = 0; i < 3; i++)
                side_reg[i] <= pr1_reg[2*i] - pr1_reg[2*i+1];
            f_t2_reg  <= f_t1_reg;
            zf_t2_reg <= zf_t1_reg;
        end
    end

    lvr_norm #(
        .W  (PROD_W),
        .SW (F_W + 1)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t2_valid_reg),
        .vec       (side_reg),
        .side_in   ({zf_t2_reg, f_t2_reg[2], f_t2_reg[1], f_t2_reg[0]}),
        .out_valid (n2_valid),
        .out_zero  (n2_zero),
        .nrm       (s2),
        .side_out  (n2_side)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr3_reg[0] <= PROD_W'(s2[1]) * PROD_W'(f_n2[2]);
            pr3_reg[1] <= PROD_W'(s2[2]) * PROD_W'(f_n2[1]);
            pr3_reg[2] <= PROD_W'(s2[2]) * PROD_W'(f_n2[0]);
            pr3_reg[3] <= PROD_W'(s2[0]) * PROD_W'(f_n2[2]);
            pr3_reg[4] <= PROD_W'(s2[0]) * PROD_W'(f_n2[1]);
            pr3_reg[5] <= PROD_W'(s2[1]) * PROD_W'(f_n2[0]);
            s_t3_reg   <= s2;
            f_t3_reg   <= f_n2;
            dg_t3_reg  <= n2_zero | n2_side[F_W];
            for (int i = 0; i < 3; i++)
                u_reg[i] <= pr3_reg[2*i] - pr3_reg[2*i+1];
            s_t4_reg  <= s_t3_reg;
            f_t4_reg  <= f_t3_reg;
            dg_t4_reg <= dg_t3_reg;
            row_reg   <= row_next;
            dg_reg    <= dg_t4_reg;
        end
    end

    always_comb
    begin
        logic [PROD_W-1:0] um;
        logic [PROD_W-1:0] ur;
        for (int i = 0; i < 3; i++)
        begin
            um = u_reg[i][PROD_W-1] ? PROD_W'(-u_reg[i]) : PROD_W'(u_reg[i]);
            ur = um + PROD_W'(64'h2000_0000);
            if (dg_t4_reg)
            begin
                row_next[i]   = '0;
                row_next[3+i] = '0;
                row_next[6+i] = '0;
            end
            else
            begin
                row_next[i]   = s_t4_reg[i];
                row_next[3+i] = sign_sat(ur[62:30], u_reg[i][PROD_W-1]);
                row_next[6+i] = -f_t4_reg[i];
            end
        end
    end

    assign res_valid  = res_valid_reg;
    assign row0_x     = row_reg[0];
    assign row0_y     = row_reg[1];
    assign row0_z     = row_reg[2];
    assign row1_x     = row_reg[3];
    assign row1_y     = row_reg[4];
    assign row1_z     = row_reg[5];
    assign row2_x     = row_reg[6];
    assign row2_y     = row_reg[7];
    assign row2_z     = row_reg[8];
    assign degenerate = dg_reg;

`ifndef NO_ASSERTIONS
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && degenerate |-> row0_x == 0 && row0_y == 0 && row0_z == 0 &&
        row1_x == 0 && row1_y == 0 && row1_z == 0 &&
        row2_x == 0 && row2_y == 0 && row2_z == 0)
        else $error("degenerate result with nonzero entries");

    a_forward_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !degenerate |->
        row2_x <= 32'sh4000_0000 && row2_x >= -32'sh4000_0000 &&
        row2_y <= 32'sh4000_0000 && row2_y >= -32'sh4000_0000 &&
        row2_z <= 32'sh4000_0000 && row2_z >= -32'sh4000_0000)
        else $error("forward row outside unit range");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(n1_valid) && $stable(n2_valid) &&
        $stable(t4_valid_reg))
        else $error("pipeline moved while the result was stalled");
`endif

endmodule
